/* hw/rtl/rcpc_pkg.sv */
// ----------------------------------------------------------------------------
// rcpc_pkg - shared constants for the RC pulse capture block
// Command codes, register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package rcpc_pkg;

    // request field widths
    localparam int CMD_W     = 2;
    localparam int CHAN_W    = 3;
    localparam int TS_W      = 32;
    localparam int POS_W     = 16;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NHIGH_W   = 15;

    // map datapath: |width - min_width| is below 2^32, |span| below 2^16
    localparam int DIVISOR_W  = 16;
    localparam int DIVIDEND_W = TS_W + DIVISOR_W;

    localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_HIGH = 2'd3;

    localparam logic [CFG_W-1:0]   MIN_WIDTH_RST = 16'd1000;
    localparam logic [CFG_W-1:0]   MAX_WIDTH_RST = 16'd2000;
    localparam logic [CFG_W-1:0]   NORM_LOW_RST  = 16'hFC18;  // -1000
    localparam logic [NHIGH_W-1:0] NORM_HIGH_RST = 15'd1000;

    localparam int LIVE_RST_INT = (2000 + 1000) / 2;
    localparam logic [TS_W-1:0] LIVE_WIDTH_RST = TS_W'(LIVE_RST_INT);

endpackage

/* hw/rtl/rcpc_div.sv */
// ----------------------------------------------------------------------------
// rcpc_div - bit-serial unsigned divider
// Restoring division of a 48-bit dividend by a 16-bit divisor, one quotient
// bit per cycle. o_done pulses for one cycle once the quotient is valid.
// ----------------------------------------------------------------------------
module rcpc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rcpc_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [rcpc_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [rcpc_pkg::DIVIDEND_W-1:0]   o_quotient
);

    localparam int DW    = rcpc_pkg::DIVIDEND_W;
    localparam int VW    = rcpc_pkg::DIVISOR_W;
    localparam int CNT_W = $clog2(DW + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DW - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_div;
    logic [DW-1:0]    r_quo;

    logic [VW:0]      trial;
    logic [VW:0]      trial_sub;
    logic             fits;
    logic [VW-1:0]    n_rem;

    // shift in the next dividend bit and subtract where the divisor fits
    always_comb begin
        trial     = {r_rem, r_quo[DW-1]};
        trial_sub = trial - {1'b0, r_div};
        fits      = (trial >= {1'b0, r_div});
        n_rem     = fits ? trial_sub[VW-1:0] : trial[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/rc_pwm_channel_capture.sv */
// ----------------------------------------------------------------------------
// rc_pwm_channel_capture - multi-channel RC servo pulse width capture
// Keeps start time and live width per channel in one memory and the snapshot
// widths in a second; reads map a snapshot width onto the normalised range.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  request   in         i_valid / o_ready      i_cmd, i_channel, i_level,
//                                              i_timestamp
//  result    out        o_valid / i_ready      o_raw_width, o_position
//  config    in         i_cfg_we (no wait)     i_cfg_idx, i_cfg_data
//
//  One request at a time. Edge: accept, memory read, write back.
//  Update: one read and one write per channel.
//  Read: runs through the 48-step bit-serial divider unless the span is zero.
//  Synchronous reset clears the per-entry valid bits at once; no clearing pass.
//  A result held on a stalled output holds the next read in its final stage,
//  where it blocks all requests; edges and updates before it go on.
// ----------------------------------------------------------------------------
module rc_pwm_channel_capture #(
    parameter int CHANNELS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // requests
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rcpc_pkg::CMD_W-1:0]        i_cmd,
    input  logic [rcpc_pkg::CHAN_W-1:0]       i_channel,
    input  logic                              i_level,
    input  logic [rcpc_pkg::TS_W-1:0]         i_timestamp,
    // results
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rcpc_pkg::TS_W-1:0]         o_raw_width,
    output logic signed [rcpc_pkg::POS_W-1:0] o_position,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rcpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rcpc_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int TW  = rcpc_pkg::TS_W;
    localparam int QW  = rcpc_pkg::DIVIDEND_W;
    localparam int VW  = rcpc_pkg::DIVISOR_W;
    localparam int PW  = rcpc_pkg::POS_W;
    localparam int NHW = rcpc_pkg::NHIGH_W;
    localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(CHANNELS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_UPD_RD,
        S_UPD_WR,
        S_READ_RD,
        S_READ_W,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FIN
    } t_state;

    // configuration registers
    logic [rcpc_pkg::CFG_W-1:0] r_min_width;
    logic [rcpc_pkg::CFG_W-1:0] r_max_width;
    logic [rcpc_pkg::CFG_W-1:0] r_norm_low;
    logic [NHW-1:0]             r_norm_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_width <= rcpc_pkg::MIN_WIDTH_RST;
            r_max_width <= rcpc_pkg::MAX_WIDTH_RST;
            r_norm_low  <= rcpc_pkg::NORM_LOW_RST;
            r_norm_high <= rcpc_pkg::NORM_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcpc_pkg::REG_MIN_WIDTH: r_min_width <= i_cfg_data;
                rcpc_pkg::REG_MAX_WIDTH: r_max_width <= i_cfg_data;
                rcpc_pkg::REG_NORM_LOW:  r_norm_low  <= i_cfg_data;
                rcpc_pkg::REG_NORM_HIGH: r_norm_high <= i_cfg_data[NHW-1:0];
                default: ;
            endcase
        end
    end

    // control and request registers
    t_state                        r_state;
    logic [rcpc_pkg::CHAN_W-1:0]   r_channel;
    logic                          r_level;
    logic [TW-1:0]                 r_ts;
    logic                          r_in_range;
    logic [AW-1:0]                 r_idx;
    logic [CHANNELS-1:0]           r_tl_vld;
    logic [CHANNELS-1:0]           r_sn_vld;
    logic                          r_tl_rd_vld;
    logic                          r_sn_rd_vld;

    // read datapath
    logic [TW-1:0]                 r_width;
    logic [TW-1:0]                 r_diff_mag;
    logic                          r_diff_neg;
    logic [QW-1:0]                 r_prod;
    logic                          r_neg;
    logic                          r_span_zero;

    // output register
    logic                          r_out_valid;
    logic [TW-1:0]                 r_raw_width;
    logic [PW-1:0]                 r_position;

    // memories: {start_time, live_width} per channel, and snapshot width
    logic [2*TW-1:0]               r_tl_mem [CHANNELS];
    logic [TW-1:0]                 r_sn_mem [CHANNELS];
    logic [2*TW-1:0]               r_tl_rd;
    logic [TW-1:0]                 r_sn_rd;

    logic                          accept;
    logic [31:0]                   in_ch_ext;
    logic [31:0]                   ch_ext;
    logic [AW-1:0]                 ch_addr;
    logic                          in_range_in;

    logic                          tl_re;
    logic [AW-1:0]                 tl_raddr;
    logic                          tl_we;
    logic [2*TW-1:0]               tl_wdata;
    logic                          sn_re;
    logic                          sn_we;

    logic [TW-1:0]                 cur_start;
    logic [TW-1:0]                 cur_live;

    logic [TW-1:0]                 w_sel;
    logic [TW+1:0]                 diff;
    logic [TW+1:0]                 diff_abs;
    logic [VW:0]                   span_in;
    logic [VW:0]                   span_in_abs;
    logic [VW+1:0]                 span_out;
    logic [VW+1:0]                 span_out_abs;
    logic [QW-1:0]                 prod;

    logic                          div_start;
    logic                          div_done;
    logic [QW-1:0]                 div_q;

    logic [QW-1:0]                 quo;
    logic [QW:0]                   scaled;
    logic signed [QW+1:0]          mapped;
    logic signed [QW+1:0]          nl_ext;
    logic signed [QW+1:0]          nh_ext;
    logic [PW-1:0]                 pos;
    logic                          out_free;

    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign in_ch_ext   = 32'(i_channel);
    assign in_range_in = (in_ch_ext < 32'(CHANNELS));
    assign ch_ext      = 32'(r_channel);
    assign ch_addr     = ch_ext[AW-1:0];

    // memory port control
    assign tl_re    = (r_state == S_EDGE_RD) || (r_state == S_UPD_RD);
    assign tl_raddr = (r_state == S_EDGE_RD) ? ch_addr : r_idx;
    assign tl_we    = (r_state == S_EDGE_WR);
    assign sn_re    = (r_state == S_READ_RD);
    assign sn_we    = (r_state == S_UPD_WR);

    // an entry never written reads as its reset value
    assign cur_start = r_tl_rd_vld ? r_tl_rd[2*TW-1:TW] : '0;
    assign cur_live  = r_tl_rd_vld ? r_tl_rd[TW-1:0] : rcpc_pkg::LIVE_WIDTH_RST;
    assign tl_wdata  = r_level ? {r_ts, cur_live} : {cur_start, r_ts - cur_start};

    always_ff @(posedge i_clk) begin
        if (tl_we) begin
            r_tl_mem[ch_addr] <= tl_wdata;
        end
        if (tl_re) begin
            r_tl_rd <= r_tl_mem[tl_raddr];
        end
        if (sn_we) begin
            r_sn_mem[r_idx] <= cur_live;
        end
        if (sn_re) begin
            r_sn_rd <= r_sn_mem[ch_addr];
        end
    end

    // map arithmetic, split over read, multiply, divide and final stages
    assign w_sel        = (r_in_range && r_sn_rd_vld) ? r_sn_rd : '0;
    assign diff         = {2'b00, w_sel} - {(TW + 2 - VW)'(0), r_min_width};
    assign diff_abs     = diff[TW+1] ? -diff : diff;
    assign span_in      = {1'b0, r_max_width} - {1'b0, r_min_width};
    assign span_in_abs  = span_in[VW] ? -span_in : span_in;
    assign span_out     = {(VW + 2 - NHW)'(0), r_norm_high}
                        - {{2{r_norm_low[VW-1]}}, r_norm_low};
    assign span_out_abs = span_out[VW+1] ? -span_out : span_out;
    assign prod         = r_diff_mag * span_out_abs[VW-1:0];

    assign div_start = (r_state == S_DIV_GO) && !r_span_zero;

    rcpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (span_in_abs[VW-1:0]),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign quo    = r_span_zero ? '0 : div_q;
    assign scaled = r_neg ? -{1'b0, quo} : {1'b0, quo};
    assign nl_ext = {{(QW + 2 - VW){r_norm_low[VW-1]}}, r_norm_low};
    assign nh_ext = {(QW + 2 - NHW)'(0), r_norm_high};
    assign mapped = $signed({scaled[QW], scaled}) + nl_ext;

    // lower bound is tested first
    always_comb begin
        priority if (mapped < nl_ext) begin
            pos = r_norm_low;
        end else if (mapped > nh_ext) begin
            pos = {1'b0, r_norm_high};
        end else begin
            pos = mapped[PW-1:0];
        end
    end

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tl_vld    <= '0;
            r_sn_vld    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_channel  <= i_channel;
                        r_level    <= i_level;
                        r_ts       <= i_timestamp;
                        r_in_range <= in_range_in;
                        r_idx      <= '0;
                        priority if (i_cmd == rcpc_pkg::CMD_EDGE && in_range_in) begin
                            r_state <= S_EDGE_RD;
                        end else if (i_cmd == rcpc_pkg::CMD_UPDATE) begin
                            r_state <= S_UPD_RD;
                        end else if (i_cmd == rcpc_pkg::CMD_READ && in_range_in) begin
                            r_state <= S_READ_RD;
                        end else if (i_cmd == rcpc_pkg::CMD_READ) begin
                            r_state <= S_READ_W;
                        end else begin
                            // drop unused commands and edges on absent channels
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EDGE_RD: begin
                    r_tl_rd_vld <= r_tl_vld[tl_raddr];
                    r_state     <= S_EDGE_WR;
                end
                S_EDGE_WR: begin
                    r_tl_vld[ch_addr] <= 1'b1;
                    r_state           <= S_IDLE;
                end
                S_UPD_RD: begin
                    r_tl_rd_vld <= r_tl_vld[tl_raddr];
                    r_state     <= S_UPD_WR;
                end
                S_UPD_WR: begin
                    r_sn_vld[r_idx] <= 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_UPD_RD;
                    end
                end
                S_READ_RD: begin
                    r_sn_rd_vld <= r_sn_vld[ch_addr];
                    r_state     <= S_READ_W;
                end
                S_READ_W: begin
                    r_width    <= w_sel;
                    r_diff_mag <= diff_abs[TW-1:0];
                    r_diff_neg <= diff[TW+1];
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    r_prod      <= prod;
                    r_neg       <= r_diff_neg ^ span_out[VW+1] ^ span_in[VW];
                    r_span_zero <= (span_in == '0);
                    r_state     <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_state <= r_span_zero ? S_FIN : S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold the result until the output register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_raw_width <= r_width;
                        r_position  <= pos;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid     = r_out_valid;
    assign o_raw_width = r_raw_width;
    assign o_position  = r_position;

endmodule

/* test/rc_pwm_channel_capture_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_channel_capture_checker - width and position checker
// Follows the request, result and configuration ports of the capture block,
// keeps its own copy of the channel timing state and the map settings, and
// compares every read result with the predicted snapshot width and position.
// ----------------------------------------------------------------------------
module rc_pwm_channel_capture_checker #(
    parameter int CHANNELS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              o_ready,
    input  logic [rcpc_pkg::CMD_W-1:0]        i_cmd,
    input  logic [rcpc_pkg::CHAN_W-1:0]       i_channel,
    input  logic                              i_level,
    input  logic [rcpc_pkg::TS_W-1:0]         i_timestamp,
    input  logic                              o_valid,
    input  logic                              i_ready,
    input  logic [rcpc_pkg::TS_W-1:0]         o_raw_width,
    input  logic signed [rcpc_pkg::POS_W-1:0] o_position,
    input  logic                              i_cfg_we,
    input  logic [rcpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rcpc_pkg::CFG_W-1:0]        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int TS_W    = rcpc_pkg::TS_W;
    localparam int POS_W   = rcpc_pkg::POS_W;
    localparam int CFG_W   = rcpc_pkg::CFG_W;
    localparam int NHIGH_W = rcpc_pkg::NHIGH_W;

    localparam logic [CFG_W-1:0]        INIT_MIN   = 16'd1000;
    localparam logic [CFG_W-1:0]        INIT_MAX   = 16'd2000;
    localparam logic signed [CFG_W-1:0] INIT_NLOW  = -16'sd1000;
    localparam logic [NHIGH_W-1:0]      INIT_NHIGH = 15'd1000;
    localparam logic [TS_W-1:0]         INIT_LIVE  = 32'd1500;

    typedef struct packed {
        logic [TS_W-1:0]  raw_width;
        logic [POS_W-1:0] position;
    } t_width_reading;

    t_width_reading pending_readings[$];

    logic [TS_W-1:0]        rise_time  [CHANNELS];
    logic [TS_W-1:0]        live_width [CHANNELS];
    logic [TS_W-1:0]        held_width [CHANNELS];
    logic [CFG_W-1:0]        cfg_min;
    logic [CFG_W-1:0]        cfg_max;
    logic signed [CFG_W-1:0] cfg_nlow;
    logic [NHIGH_W-1:0]      cfg_nhigh;

    // Full precision map onto [norm_low, norm_high], truncating divide,
    // lower bound tested first.
    function automatic logic [POS_W-1:0] predict_position(input logic [TS_W-1:0] width);
        longint w, lo_w, hi_w, n_lo, n_hi, span_in, span_out, scaled, mapped;
        w        = width;
        lo_w     = cfg_min;
        hi_w     = cfg_max;
        n_lo     = cfg_nlow;
        n_hi     = cfg_nhigh;
        span_in  = hi_w - lo_w;
        span_out = n_hi - n_lo;
        scaled   = 0;
        if (span_in != 0) begin
            scaled = ((w - lo_w) * span_out) / span_in;
        end
        mapped = scaled + n_lo;
        if (mapped < n_lo) begin
            mapped = n_lo;
        end else if (mapped > n_hi) begin
            mapped = n_hi;
        end
        return mapped[POS_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_width_reading want;
        logic [TS_W-1:0] width;
        if (!i_rst_n) begin
            cfg_min   = INIT_MIN;
            cfg_max   = INIT_MAX;
            cfg_nlow  = INIT_NLOW;
            cfg_nhigh = INIT_NHIGH;
            for (int c = 0; c < CHANNELS; c++) begin
                rise_time[c]  = '0;
                live_width[c] = INIT_LIVE;
                held_width[c] = '0;
            end
            pending_readings.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (pending_readings.size() == 0) begin
                    $error("result raw_width %0d position %0d with no read waiting",
                           o_raw_width, o_position);
                    o_fail_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (o_raw_width !== want.raw_width) begin
                        $error("raw_width: expected %0d, got %0d", want.raw_width, o_raw_width);
                        o_fail_count++;
                    end
                    if (o_position !== want.position) begin
                        $error("position: expected %0d, got %0d",
                               $signed(want.position), o_position);
                        o_fail_count++;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rcpc_pkg::REG_MIN_WIDTH: cfg_min   = i_cfg_data;
                    rcpc_pkg::REG_MAX_WIDTH: cfg_max   = i_cfg_data;
                    rcpc_pkg::REG_NORM_LOW:  cfg_nlow  = i_cfg_data;
                    rcpc_pkg::REG_NORM_HIGH: cfg_nhigh = i_cfg_data[NHIGH_W-1:0];
                    default: ;
                endcase
            end

            if (i_valid && o_ready) begin
                case (i_cmd)
                    rcpc_pkg::CMD_EDGE: begin
                        // drop edges on channels that do not exist
                        if (i_channel < CHANNELS) begin
                            if (i_level) begin
                                rise_time[i_channel] = i_timestamp;
                            end else begin
                                live_width[i_channel] = i_timestamp - rise_time[i_channel];
                            end
                        end
                    end
                    rcpc_pkg::CMD_UPDATE: begin
                        for (int c = 0; c < CHANNELS; c++) begin
                            held_width[c] = live_width[c];
                        end
                    end
                    rcpc_pkg::CMD_READ: begin
                        width = (i_channel < CHANNELS) ? held_width[i_channel] : '0;
                        want.raw_width = width;
                        want.position  = predict_position(width);
                        pending_readings.push_back(want);
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= pending_readings.size();
    end

endmodule

/* test/rc_pwm_channel_capture_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_pwm_channel_capture_test - testbench for the RC pulse capture block
// Drives directed and random edge, update and read requests through several
// map settings with random idling on both sides; a separate checker predicts
// every read result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module rc_pwm_channel_capture_test;

    localparam int CMD_W     = rcpc_pkg::CMD_W;
    localparam int CHAN_W    = rcpc_pkg::CHAN_W;
    localparam int TS_W      = rcpc_pkg::TS_W;
    localparam int POS_W     = rcpc_pkg::POS_W;
    localparam int CFG_W     = rcpc_pkg::CFG_W;
    localparam int CFG_IDX_W = rcpc_pkg::CFG_IDX_W;

    localparam int CHANNELS      = 6;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int NUM_SETTINGS  = 9;
    localparam int SETTLE_CYCLES = 24;
    localparam int TAIL_CYCLES   = 80;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [CMD_W-1:0]         i_cmd;
    logic [CHAN_W-1:0]        i_channel;
    logic                     i_level;
    logic [TS_W-1:0]          i_timestamp;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [TS_W-1:0]          o_raw_width;
    logic signed [POS_W-1:0]  o_position;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_W-1:0]         i_cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles;
    int tx_idle_pct = 22;
    int rx_idle_pct = 84;

    logic [TS_W-1:0]  clock_us;
    logic [CFG_W-1:0] cur_min;
    logic [CFG_W-1:0] cur_max;
    logic [CFG_W-1:0] set_min   [NUM_SETTINGS];
    logic [CFG_W-1:0] set_max   [NUM_SETTINGS];
    logic [CFG_W-1:0] set_nlow  [NUM_SETTINGS];
    logic [CFG_W-1:0] set_nhigh [NUM_SETTINGS];

    rc_pwm_channel_capture #(
        .CHANNELS (CHANNELS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_channel   (i_channel),
        .i_level     (i_level),
        .i_timestamp (i_timestamp),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_raw_width (o_raw_width),
        .o_position  (o_position),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    rc_pwm_channel_capture_checker #(
        .CHANNELS (CHANNELS)
    ) width_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_channel    (i_channel),
        .i_level      (i_level),
        .i_timestamp  (i_timestamp),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_raw_width  (o_raw_width),
        .o_position   (o_position),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // count cycles in which nothing moves on any port
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                                input logic lvl, input logic [TS_W-1:0] ts);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_channel   <= chan;
        i_level     <= lvl;
        i_timestamp <= ts;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_pulse(input logic [CHAN_W-1:0] chan, input logic [TS_W-1:0] rise_ts,
                              input logic [TS_W-1:0] width);
        send_request(rcpc_pkg::CMD_EDGE, chan, 1'b1, rise_ts);
        send_request(rcpc_pkg::CMD_EDGE, chan, 1'b0, rise_ts + width);
    endtask

    // hold off new requests until every read has been answered
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic write_setting(input logic [CFG_W-1:0] min_w, input logic [CFG_W-1:0] max_w,
                                 input logic [CFG_W-1:0] nlow, input logic [CFG_W-1:0] nhigh);
        write_reg(rcpc_pkg::REG_MIN_WIDTH, min_w);
        write_reg(rcpc_pkg::REG_MAX_WIDTH, max_w);
        write_reg(rcpc_pkg::REG_NORM_LOW, nlow);
        write_reg(rcpc_pkg::REG_NORM_HIGH, nhigh);
        i_cfg_we <= 1'b0;
        cur_min = min_w;
        cur_max = max_w;
    endtask

    task automatic random_request(output int counted);
        int pick;
        logic [TS_W-1:0] width;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        pick    = $urandom_range(99);
        counted = 1;
        if (pick < 50) begin
            lo = (cur_min < cur_max) ? cur_min : cur_max;
            hi = (cur_min < cur_max) ? cur_max : cur_min;
            case ($urandom_range(9))
                0, 1:    width = $urandom;
                2:       width = $urandom_range(3);
                default: width = $urandom_range((lo > 300) ? lo - 300 : 0, hi + 300);
            endcase
            if ($urandom_range(29) == 0) begin
                clock_us = $urandom;
            end
            clock_us += $urandom_range(1, 40000);
            send_pulse(CHAN_W'($urandom_range(CHANNELS - 1)), clock_us, width);
            clock_us += width;
            counted = 2;
        end else if (pick < 60) begin
            send_request(rcpc_pkg::CMD_UPDATE, CHAN_W'($urandom_range(7)),
                         1'($urandom_range(1)), $urandom);
        end else if (pick < 85) begin
            send_request(rcpc_pkg::CMD_READ, CHAN_W'($urandom_range(CHANNELS - 1)),
                         1'($urandom_range(1)), $urandom);
        end else if (pick < 90) begin
            send_request(rcpc_pkg::CMD_READ, CHAN_W'($urandom_range(7, CHANNELS)),
                         1'($urandom_range(1)), $urandom);
        end else if (pick < 95) begin
            // lone edge, breaks the rise/fall pairing
            send_request(rcpc_pkg::CMD_EDGE, CHAN_W'($urandom_range(CHANNELS - 1)),
                         1'($urandom_range(1)), $urandom);
        end else begin
            counted = 0;
            if ($urandom_range(1)) begin
                send_request(CMD_UNUSED, CHAN_W'($urandom_range(7)),
                             1'($urandom_range(1)), $urandom);
            end else begin
                send_request(rcpc_pkg::CMD_EDGE, CHAN_W'($urandom_range(7, CHANNELS)),
                             1'($urandom_range(1)), $urandom);
            end
        end
    endtask

    initial begin
        int counted;
        int phase_items;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= rcpc_pkg::CMD_EDGE;
        i_channel   <= '0;
        i_level     <= 1'b0;
        i_timestamp <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= rcpc_pkg::REG_MIN_WIDTH;
        i_cfg_data  <= '0;
        cur_min  = 16'd1000;
        cur_max  = 16'd2000;
        clock_us = $urandom;

        set_min[0] = 16'd1000;  set_max[0] = 16'd2000;  set_nlow[0] = 16'hFC18; set_nhigh[0] = 16'd1000;
        set_min[1] = 16'd1500;  set_max[1] = 16'd1500;  set_nlow[1] = 16'hFE0C; set_nhigh[1] = 16'd500;
        set_min[2] = 16'd2000;  set_max[2] = 16'd1000;  set_nlow[2] = 16'hFC18; set_nhigh[2] = 16'd1000;
        set_min[3] = 16'd0;     set_max[3] = 16'hFFFF;  set_nlow[3] = 16'h8000; set_nhigh[3] = 16'h7FFF;
        set_min[4] = 16'd1000;  set_max[4] = 16'd2000;  set_nlow[4] = 16'd500;  set_nhigh[4] = 16'd100;
        set_min[5] = 16'd0;     set_max[5] = 16'd1;     set_nlow[5] = 16'd0;    set_nhigh[5] = 16'd0;
        set_min[6] = 16'hFFFE;  set_max[6] = 16'hFFFF;  set_nlow[6] = 16'd0;    set_nhigh[6] = 16'hFFFF;
        for (int s = 7; s < NUM_SETTINGS; s++) begin
            set_min[s]   = CFG_W'($urandom_range(500, 1500));
            set_max[s]   = CFG_W'(set_min[s] + $urandom_range(1, 1500));
            set_nlow[s]  = CFG_W'(0 - int'($urandom_range(0, 32768)));
            set_nhigh[s] = CFG_W'($urandom_range(0, 65535));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset map settings
        send_request(rcpc_pkg::CMD_READ, 3'd0, 1'b0, 32'd0);
        send_request(rcpc_pkg::CMD_UPDATE, 3'd0, 1'b0, 32'd0);
        send_request(rcpc_pkg::CMD_READ, 3'd1, 1'b1, 32'hFFFF_FFFF);
        send_pulse(3'd2, 32'hFFFF_FF00, 32'h0000_0600);
        send_pulse(3'd3, 32'd100, 32'd0);
        send_pulse(3'd4, 32'd0, 32'hFFFF_FFFF);
        send_pulse(3'd0, 32'd12345, 32'd1000);
        send_pulse(3'd1, 32'd5, 32'd2000);
        send_request(rcpc_pkg::CMD_EDGE, 3'd6, 1'b1, 32'hFFFF_FFFF);
        send_request(rcpc_pkg::CMD_EDGE, 3'd7, 1'b0, 32'h0000_0001);
        send_request(CMD_UNUSED, 3'd5, 1'b1, 32'hA5A5_A5A5);
        // fall with no rise seen since reset
        send_request(rcpc_pkg::CMD_EDGE, 3'd5, 1'b0, 32'd777);
        send_request(rcpc_pkg::CMD_UPDATE, 3'd7, 1'b1, 32'h5A5A_5A5A);
        for (int c = 0; c < (1 << CHAN_W); c++) begin
            send_request(rcpc_pkg::CMD_READ, CHAN_W'(c), 1'b0, 32'd0);
        end

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            drain_results();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            if (s < 3) begin
                tx_idle_pct = 22;
                rx_idle_pct = 84;
            end else if (s < 6) begin
                tx_idle_pct = 84;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_setting(set_min[s], set_max[s], set_nlow[s], set_nhigh[s]);
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / NUM_SETTINGS) begin
                random_request(counted);
                phase_items += counted;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
